[rtl/core/integer_to_ascii_radix_unit_defines.svh]
// Assertion macros for the radix converter back end.
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ITOA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("itoa assertion failed");
`define ITOA_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("itoa forbidden condition seen");
`else
`define ITOA_ASSERT(lbl, clk, rst, prop)
`define ITOA_NEVER(lbl, clk, rst, expr)
`endif
`endif

[rtl/core/itoa_pkg.sv]
// Types, constants and helpers of the radix converter.
package itoa_pkg;

   localparam int VALUE_W = 32;
   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd97;

   // divider retires this many quotient bits per cycle
   localparam int DIV_BITS   = 8;
   localparam int DIV_CYCLES = VALUE_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
   } work_type;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [RADIX_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) res = RADIX_MIN;
      if (r > RADIX_MAX) res = RADIX_MAX;
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d >= DIGIT_TEN) begin
         c = CHAR_A + {1'b0, d} - {1'b0, DIGIT_TEN};
      end else begin
         c = CHAR_ZERO + {1'b0, d};
      end
      return c;
   endfunction

endpackage

[rtl/core/itoa_front.sv]
// Front end: radix register, input word capture and two-entry work queue.
module itoa_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [itoa_pkg::RADIX_W-1:0] csr_wdata,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [itoa_pkg::VALUE_W-1:0] req_value,
   output logic                         q_valid,
   output itoa_pkg::work_type           q_item,
   input  logic                         q_take
);

   logic [itoa_pkg::RADIX_W-1:0] radix_ff;
   itoa_pkg::work_type           slot_ff [2];
   logic                         wr_ptr_ff, wr_ptr_in;
   logic                         rd_ptr_ff, rd_ptr_in;
   logic [1:0]                   count_ff, count_in;
   logic                         push_ok;
   logic                         take_ok;
   itoa_pkg::work_type           new_item;

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign take_ok  = q_take && q_valid;

   // radix is clamped into 2..36 as the word enters
   assign new_item.value = req_value;
   assign new_item.radix = itoa_pkg::clamp_radix(radix_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ take_ok;
      count_in  = count_ff;
      if (push_ok && !take_ok) count_in = count_ff + 2'd1;
      if (take_ok && !push_ok) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= itoa_pkg::RADIX_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (csr_we) radix_ff <= csr_wdata;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) slot_ff[wr_ptr_ff] <= new_item;
   end

endmodule

[rtl/core/itoa_div.sv]
// Iterative divider of a 32-bit word by a small radix, several bits a cycle.
module itoa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  itoa_pkg::div_req_type div_req,
   output itoa_pkg::div_rsp_type div_rsp
);

   logic [itoa_pkg::VALUE_W-1:0]   work_ff, work_in;
   logic [itoa_pkg::DIGIT_W-1:0]   rem_ff, rem_in;
   logic [itoa_pkg::RADIX_W-1:0]   base_ff;
   logic [itoa_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [itoa_pkg::DIGIT_W:0]     trial;

   // shift dividend bits out of the top, quotient bits in at the bottom
   always_comb begin
      rem_in  = rem_ff;
      work_in = work_ff;
      trial   = '0;
      for (int i = 0; i < itoa_pkg::DIV_BITS; i++) begin
         trial   = {rem_in, work_in[itoa_pkg::VALUE_W-1]};
         work_in = {work_in[itoa_pkg::VALUE_W-2:0], 1'b0};
         if (trial >= {1'b0, base_ff}) begin
            trial      = trial - {1'b0, base_ff};
            work_in[0] = 1'b1;
         end
         rem_in = trial[itoa_pkg::DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == itoa_pkg::DIV_CNT_W'(itoa_pkg::DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         work_ff <= div_req.dividend;
         rem_ff  <= '0;
         base_ff <= div_req.divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = work_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[rtl/core/itoa_back.sv]
// Back end: digit loop over the divider, digit store and character output.
`include "integer_to_ascii_radix_unit_defines.svh"

module itoa_back #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  itoa_pkg::work_type          q_item,
   output logic                        q_take,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [itoa_pkg::CHAR_W-1:0] rsp_digit_char,
   output logic                        rsp_last_char
);

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [IDX_W-1:0]              emit_idx_ff, emit_idx_in;
   logic [itoa_pkg::RADIX_W-1:0]  radix_ff, radix_in;
   logic                          rd_pend_ff;
   logic                          rd_last_ff;
   logic [itoa_pkg::DIGIT_W-1:0]  rd_data_ff;
   logic                          out_valid_ff;
   logic [itoa_pkg::CHAR_W-1:0]   out_char_ff;
   logic                          out_last_ff;
   logic [itoa_pkg::DIGIT_W-1:0]  digit_mem [MAX_DIGITS];

   itoa_pkg::div_req_type div_req;
   itoa_pkg::div_rsp_type div_rsp;

   logic pop_ok;
   logic issue;
   logic digit_wr;
   logic finish;

   itoa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign pop_ok   = rsp_pop && out_valid_ff;
   assign issue    = (state_ff == ST_EMIT) && !rd_pend_ff && (!out_valid_ff || pop_ok);
   assign digit_wr = (state_ff == ST_DIV) && div_rsp.done;
   assign finish   = (div_rsp.quotient == '0) || (cnt_ff == CNT_W'(MAX_DIGITS - 1));

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      emit_idx_in      = emit_idx_ff;
      radix_in         = radix_ff;
      q_take           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = q_item.value;
      div_req.divisor  = q_item.radix;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take        = 1'b1;
               div_req.start = 1'b1;
               radix_in      = q_item.radix;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = radix_ff;
            if (div_rsp.done) begin
               cnt_in = cnt_ff + 1'b1;
               if (finish) begin
                  emit_idx_in = cnt_ff[IDX_W-1:0];
                  state_in    = ST_EMIT;
               end else begin
                  div_req.start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               emit_idx_in = emit_idx_ff - 1'b1;
               if (emit_idx_ff == '0) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         emit_idx_ff  <= '0;
         radix_ff     <= itoa_pkg::RADIX_RESET;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         emit_idx_ff <= emit_idx_in;
         radix_ff    <= radix_in;
         rd_pend_ff  <= issue;
         // a read is only issued into a free output slot
         if (rd_pend_ff) begin
            out_valid_ff <= 1'b1;
         end else if (pop_ok) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (digit_wr) digit_mem[cnt_ff[IDX_W-1:0]] <= div_rsp.remainder;
      if (issue) begin
         rd_data_ff <= digit_mem[emit_idx_ff];
         rd_last_ff <= (emit_idx_ff == '0);
      end
      if (rd_pend_ff) begin
         out_char_ff <= itoa_pkg::digit_to_ascii(rd_data_ff);
         out_last_ff <= rd_last_ff;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last_char  = out_last_ff;

   `ITOA_ASSERT(a_cnt_range, clock, reset, cnt_ff <= CNT_W'(MAX_DIGITS))
   `ITOA_NEVER(a_read_into_full, clock, reset, rd_pend_ff && out_valid_ff)
   `ITOA_ASSERT(a_last_to_idle, clock, reset, (issue && emit_idx_ff == '0) |=> state_ff == ST_IDLE)

endmodule

[rtl/core/integer_to_ascii_radix_unit.sv]
// Top level of the unsigned integer to ASCII text converter.
//
// Input queue: push a 32-bit word on req_value with req_push while req_full
// is low. Output queue: while rsp_empty is low, rsp_digit_char holds the next
// character ('0'-'9', then 'a'-'z'), most significant first, and
// rsp_last_char marks the final character of the word; rsp_pop takes it.
// csr_we with csr_wdata writes the radix (values below 2 act as 2, above 36
// as 36). Write it only while no word is in flight.
// A two-word queue sits between input and the digit loop. Each digit passes
// through the iterative divider (eight quotient bits a cycle, then a hand-over
// to the next division), and each character through the digit store read and
// the output register. Zero gives one character '0'. At most MAX_DIGITS low
// digits are produced. Reset empties both queues and sets the radix to ten.
// When the output is not popped, emission stops with one character held;
// conversion of a queued word then waits, and req_full rises once two words
// are queued.
module integer_to_ascii_radix_unit #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [itoa_pkg::RADIX_W-1:0] csr_wdata,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [itoa_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [itoa_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last_char
);

   logic               q_valid;
   logic               q_take;
   itoa_pkg::work_type q_item;

   itoa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_take    (q_take)
   );

   itoa_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_take         (q_take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule
